// ----- sv/wavetable_store_interpolated_read_defines.svh -----
// assertion helpers for the wavetable block
`ifndef WAVETABLE_STORE_INTERPOLATED_READ_DEFINES_SVH
`define WAVETABLE_STORE_INTERPOLATED_READ_DEFINES_SVH

// same-cycle implication, held off while in reset
`define WT_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("wavetable assertion failed");

// next-cycle implication, held off while in reset
`define WT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("wavetable assertion failed");

`endif

// ----- sv/wt_pkg.sv -----
package wt_pkg;

    localparam int TABLE_DEPTH  = 1024;
    localparam int ADDR_WIDTH   = 10;
    localparam int SAMPLE_WIDTH = 24;
    localparam int PHASE_WIDTH  = 32;
    localparam int QUARTER_LEN  = TABLE_DEPTH / 4 + 1;
    localparam int IN_WIDTH     = 96;
    localparam int OUT_WIDTH    = 32;

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0,
        CMD_WRITE = 3'd1,
        CMD_HARM  = 3'd2,
        CMD_NORM  = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    // q30 taylor terms of sin(pi/2 x)
    localparam logic [63:0] SIN_A = 64'd1686629713;
    localparam logic [63:0] SIN_B = 64'd693598668;
    localparam logic [63:0] SIN_C = 64'd85569306;
    localparam logic [63:0] SIN_E = 64'd5026995;

    typedef logic [16:0] quarter_rom_t [QUARTER_LEN];

    // quarter wave magnitudes in q16, entry i is sin(pi/2 * i/256)
    function automatic quarter_rom_t build_quarter();
        quarter_rom_t rom;
        logic [63:0]  z;
        logic [63:0]  z2;
        logic [63:0]  r;
        logic [63:0]  s;
        for (int i = 0; i < QUARTER_LEN; i++) begin
            z  = 64'(i) << 22;
            z2 = (z * z) >> 30;
            r  = SIN_E;
            r  = SIN_C - ((z2 * r) >> 30);
            r  = SIN_B - ((z2 * r) >> 30);
            r  = SIN_A - ((z2 * r) >> 30);
            s  = (z * r) >> 30;
            rom[i] = 17'((s + 64'd8192) >> 14);
        end
        return rom;
    endfunction

    localparam quarter_rom_t SINE_QUARTER = build_quarter();

endpackage

// ----- sv/wavetable_store_interpolated_read.sv -----
// Wavetable store with harmonic build, peak normalise and interpolated read. One beat in
// gives one beat out. All table work goes through a single 1024 x 24 synchronous memory
// with one read and one write port. A write is stored when its beat is taken; interpolated
// read makes two fetches, a multiply and an add; clear sweeps every entry; add-harmonic
// streams read, multiply and saturating write; normalise runs a peak scan, then per entry
// a read, wait, 17-step restoring divide and write back. Undefined commands return a zero
// result. After reset a clearing pass zeroes the table while s_tready stays low. A new
// beat is taken while a result still waits on the master side.
`include "wavetable_store_interpolated_read_defines.svh"

module wavetable_store_interpolated_read (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // command[2:0], entry_index[12:3], entry_value[36:13], harmonic_multiplier[46:37],
    // harmonic_amplitude[62:47], phase[94:63], zero[95]
    input  logic [wt_pkg::IN_WIDTH-1:0]      s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // sample[23:0], table_silent[24], zero[31:25]
    output logic [wt_pkg::OUT_WIDTH-1:0]     m_tdata
);

    // one-hot sequencer states
    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_CLEAR  = 13'b0000000000010,
        S_HARM   = 13'b0000000000100,
        S_PEAK   = 13'b0000000001000,
        S_NRD    = 13'b0000000010000,
        S_NWAIT  = 13'b0000000100000,
        S_DIV    = 13'b0000001000000,
        S_NWR    = 13'b0000010000000,
        S_RD0    = 13'b0000100000000,
        S_RD1    = 13'b0001000000000,
        S_RD2    = 13'b0010000000000,
        S_RD3    = 13'b0100000000000,
        S_FINISH = 13'b1000000000000
    } state_t;

    // input fields
    logic [2:0]         in_cmd;
    logic [9:0]         in_index;
    logic [23:0]        in_value;
    logic [9:0]         in_mult;
    logic signed [15:0] in_amp;
    logic [31:0]        in_phase;

    assign in_cmd   = s_tdata[2:0];
    assign in_index = s_tdata[12:3];
    assign in_value = s_tdata[36:13];
    assign in_mult  = s_tdata[46:37];
    assign in_amp   = $signed(s_tdata[62:47]);
    assign in_phase = s_tdata[94:63];

    state_t state_reg, state_next;
    logic [10:0]        cnt_reg, cnt_next;          // sweep position, top bit marks the end
    logic [9:0]         k_reg, k_next;              // sine index m*j mod depth
    logic               clr_cmd_reg, clr_cmd_next;  // clear came from a command
    logic [9:0]         mult_reg, mult_next;
    logic signed [15:0] amp_reg, amp_next;
    logic [9:0]         lo_idx_reg, lo_idx_next;
    logic [15:0]        frac_reg, frac_next;
    logic               v1_reg, v1_next;            // memory and rom data valid
    logic               v2_reg, v2_next;            // product valid
    logic [9:0]         a1_reg, a1_next;
    logic [9:0]         a2_reg, a2_next;
    logic signed [23:0] data2_reg, data2_next;
    logic signed [41:0] prod_reg, prod_next;
    logic signed [23:0] lo_reg, lo_next;
    logic [23:0]        peak_reg, peak_next;
    logic               neg_reg, neg_next;
    logic [23:0]        rem_reg, rem_next;
    logic [16:0]        ndiv_reg, ndiv_next;
    logic [16:0]        quot_reg, quot_next;
    logic [4:0]         step_reg, step_next;
    logic signed [23:0] res_sample_reg, res_sample_next;
    logic               res_silent_reg, res_silent_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [23:0]        m_sample_reg, m_sample_next;
    logic               m_silent_reg, m_silent_next;

    // table memory
    logic [23:0]        wave_mem [wt_pkg::TABLE_DEPTH];
    logic signed [23:0] mem_q_reg;
    logic               mem_we;
    logic [9:0]         mem_waddr;
    logic [23:0]        mem_wdata;
    logic [9:0]         mem_raddr;

    // sine rom, registered read
    logic signed [17:0] rom_q_reg;
    logic [8:0]         rom_qi;
    logic [16:0]        rom_mag;

    logic               s_accept;
    logic               out_load;
    logic               issue;
    logic [23:0]        abs_q;
    logic [40:0]        div_num;
    logic [24:0]        div_trial;
    logic               div_ge;
    logic [24:0]        div_diff;
    logic signed [33:0] harm_prod;
    logic signed [33:0] harm_rnd;
    logic signed [24:0] harm_sum;
    logic signed [24:0] rd_diff;
    logic signed [41:0] rd_rnd;
    logic [23:0]        quot_signed;

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == S_FINISH) && (!m_tvalid_reg || m_tready);
    assign issue    = !cnt_reg[10];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, m_silent_reg, m_sample_reg};

    // quarter-wave symmetry: odd quadrants mirror, upper half negates
    assign rom_qi  = k_reg[8] ? (9'd256 - {1'b0, k_reg[7:0]}) : {1'b0, k_reg[7:0]};
    assign rom_mag = wt_pkg::SINE_QUARTER[rom_qi];

    always_ff @(posedge aclk) begin
        if (k_reg[9]) begin
            rom_q_reg <= -$signed({1'b0, rom_mag});
        end else begin
            rom_q_reg <= $signed({1'b0, rom_mag});
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            wave_mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= $signed(wave_mem[mem_raddr]);
    end

    // datapath helpers
    assign abs_q       = mem_q_reg[23] ? 24'(-mem_q_reg) : 24'(mem_q_reg);
    assign div_num     = {1'b0, abs_q, 16'd0} + {18'd0, peak_reg[23:1]};
    assign div_trial   = {rem_reg, ndiv_reg[16]};
    assign div_ge      = div_trial >= {1'b0, peak_reg};
    assign div_diff    = div_trial - {1'b0, peak_reg};
    assign harm_prod   = amp_reg * rom_q_reg;
    assign harm_rnd    = (prod_reg[33:0] + 34'sd8192) >>> 14;
    assign harm_sum    = 25'(data2_reg) + 25'($signed(harm_rnd[19:0]));
    assign rd_diff     = 25'(mem_q_reg) - 25'(lo_reg);
    assign rd_rnd      = (prod_reg + 42'sd32768) >>> 16;
    assign quot_signed = neg_reg ? 24'(-{7'd0, quot_reg}) : {7'd0, quot_reg};

    // read address select
    always_comb begin
        unique case (state_reg)
            S_HARM, S_PEAK, S_NRD: mem_raddr = cnt_reg[9:0];
            S_RD0:                 mem_raddr = lo_idx_reg;
            S_RD1:                 mem_raddr = lo_idx_reg + 10'd1;
            default:               mem_raddr = 10'd0;
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        k_next          = k_reg;
        clr_cmd_next    = clr_cmd_reg;
        mult_next       = mult_reg;
        amp_next        = amp_reg;
        lo_idx_next     = lo_idx_reg;
        frac_next       = frac_reg;
        v1_next         = 1'b0;
        v2_next         = 1'b0;
        a1_next         = a1_reg;
        a2_next         = a2_reg;
        data2_next      = data2_reg;
        prod_next       = prod_reg;
        lo_next         = lo_reg;
        peak_next       = peak_reg;
        neg_next        = neg_reg;
        rem_next        = rem_reg;
        ndiv_next       = ndiv_reg;
        quot_next       = quot_reg;
        step_next       = step_reg;
        res_sample_next = res_sample_reg;
        res_silent_next = res_silent_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_sample_next   = m_sample_reg;
        m_silent_next   = m_silent_reg;
        mem_we          = 1'b0;
        mem_waddr       = cnt_reg[9:0];
        mem_wdata       = 24'd0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    res_sample_next = '0;
                    res_silent_next = 1'b0;
                    cnt_next        = '0;
                    k_next          = '0;
                    priority if (in_cmd == wt_pkg::CMD_CLEAR) begin
                        clr_cmd_next = 1'b1;
                        state_next   = S_CLEAR;
                    end else if (in_cmd == wt_pkg::CMD_WRITE) begin
                        mem_we     = 1'b1;
                        mem_waddr  = in_index;
                        mem_wdata  = in_value;
                        state_next = S_FINISH;
                    end else if (in_cmd == wt_pkg::CMD_HARM) begin
                        mult_next  = in_mult;
                        amp_next   = in_amp;
                        state_next = S_HARM;
                    end else if (in_cmd == wt_pkg::CMD_NORM) begin
                        peak_next  = '0;
                        state_next = S_PEAK;
                    end else if (in_cmd == wt_pkg::CMD_READ) begin
                        // index is the top address bits, fraction the next 16
                        lo_idx_next = in_phase[31:22];
                        frac_next   = in_phase[21:6];
                        state_next  = S_RD0;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                cnt_next  = cnt_reg + 11'd1;
                if (cnt_reg[9:0] == 10'(wt_pkg::TABLE_DEPTH - 1)) begin
                    state_next = clr_cmd_reg ? S_FINISH : S_IDLE;
                end
            end
            S_HARM: begin
                // read j, then multiply, then saturating write back at j
                if (issue) begin
                    v1_next  = 1'b1;
                    a1_next  = cnt_reg[9:0];
                    cnt_next = cnt_reg + 11'd1;
                    k_next   = k_reg + mult_reg;
                end
                if (v1_reg) begin
                    v2_next    = 1'b1;
                    a2_next    = a1_reg;
                    data2_next = mem_q_reg;
                    prod_next  = 42'(harm_prod);
                end
                if (v2_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = a2_reg;
                    if (harm_sum > 25'sd8388607) begin
                        mem_wdata = 24'h7FFFFF;
                    end else if (harm_sum < -25'sd8388608) begin
                        mem_wdata = 24'h800000;
                    end else begin
                        mem_wdata = harm_sum[23:0];
                    end
                end
                if (!issue && !v1_reg && !v2_reg) begin
                    state_next = S_FINISH;
                end
            end
            S_PEAK: begin
                if (issue) begin
                    v1_next  = 1'b1;
                    cnt_next = cnt_reg + 11'd1;
                end
                if (v1_reg && (abs_q > peak_reg)) begin
                    peak_next = abs_q;
                end
                if (!issue && !v1_reg) begin
                    cnt_next = '0;
                    if (peak_reg == '0) begin
                        res_silent_next = 1'b1;
                        state_next      = S_FINISH;
                    end else begin
                        state_next = S_NRD;
                    end
                end
            end
            S_NRD: begin
                state_next = S_NWAIT;
            end
            S_NWAIT: begin
                // quotient stays below 2^17, so the top bits start as remainder
                neg_next   = mem_q_reg[23];
                rem_next   = div_num[40:17];
                ndiv_next  = div_num[16:0];
                step_next  = '0;
                state_next = S_DIV;
            end
            S_DIV: begin
                rem_next  = div_ge ? div_diff[23:0] : div_trial[23:0];
                quot_next = {quot_reg[15:0], div_ge};
                ndiv_next = {ndiv_reg[15:0], 1'b0};
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd16) begin
                    state_next = S_NWR;
                end
            end
            S_NWR: begin
                mem_we    = 1'b1;
                mem_wdata = quot_signed;
                cnt_next  = cnt_reg + 11'd1;
                if (cnt_reg[9:0] == 10'(wt_pkg::TABLE_DEPTH - 1)) begin
                    state_next = S_FINISH;
                end else begin
                    state_next = S_NRD;
                end
            end
            S_RD0: begin
                state_next = S_RD1;
            end
            S_RD1: begin
                lo_next    = mem_q_reg;
                state_next = S_RD2;
            end
            S_RD2: begin
                prod_next  = rd_diff * $signed({1'b0, frac_reg});
                state_next = S_RD3;
            end
            S_RD3: begin
                res_sample_next = lo_reg + rd_rnd[23:0];
                state_next      = S_FINISH;
            end
            S_FINISH: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_sample_next = res_sample_reg;
                    m_silent_next = res_silent_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            clr_cmd_reg  <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            clr_cmd_reg  <= clr_cmd_next;
            v1_reg       <= v1_next;
            v2_reg       <= v2_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg          <= k_next;
        mult_reg       <= mult_next;
        amp_reg        <= amp_next;
        lo_idx_reg     <= lo_idx_next;
        frac_reg       <= frac_next;
        a1_reg         <= a1_next;
        a2_reg         <= a2_next;
        data2_reg      <= data2_next;
        prod_reg       <= prod_next;
        lo_reg         <= lo_next;
        peak_reg       <= peak_next;
        neg_reg        <= neg_next;
        rem_reg        <= rem_next;
        ndiv_reg       <= ndiv_next;
        quot_reg       <= quot_next;
        step_reg       <= step_next;
        res_sample_reg <= res_sample_next;
        res_silent_reg <= res_silent_next;
        m_sample_reg   <= m_sample_next;
        m_silent_reg   <= m_silent_next;
    end

    // the divider only ever runs against a non-zero peak
    `WT_ASSERT_IMPLY(a_div_peak_nz, aclk, aresetn, state_reg == S_DIV, peak_reg != '0)
    // a normalised magnitude never exceeds 1.0
    `WT_ASSERT_IMPLY(a_quot_range, aclk, aresetn, state_reg == S_NWR, quot_reg <= 17'd65536)
    // a finished result always reaches the output register
    `WT_ASSERT_NEXT(a_fin_loads, aclk, aresetn, out_load, m_tvalid_reg && state_reg == S_IDLE)

endmodule

// ----- tb/wavetable_store_interpolated_read_test.sv -----
`timescale 1ns / 100ps

module wavetable_store_interpolated_read_test;

    // command codes the block does nothing with
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
    localparam int         STALL_LIMIT     = 200000;
    localparam int         RANDOM_BEATS    = 2000;

    typedef struct packed {
        logic [31:0]        phase;
        logic signed [15:0] amp;
        logic [9:0]         mult;
        logic signed [23:0] value;
        logic [9:0]         index;
        logic [2:0]         cmd;
    } wave_cmd_t;

    typedef struct packed {
        logic        silent;
        logic [23:0] sample;
    } wave_result_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [wt_pkg::IN_WIDTH-1:0]  s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [wt_pkg::OUT_WIDTH-1:0] m_tdata;

    wave_cmd_t    pending_cmds[$];
    wave_result_t expected_results[$];
    wave_cmd_t    offered_cmd;
    longint       shadow_table[wt_pkg::TABLE_DEPTH];
    longint       sine_q16[wt_pkg::TABLE_DEPTH];
    int           beats_in = 0;
    int           beats_out = 0;
    int           idle_cycles = 0;
    int           hold_left = 0;
    bit           hold_done = 0;
    bit           failed = 0;

    always #5 aclk = ~aclk;

    wavetable_store_interpolated_read dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic longint clamp_sample(longint v);
        if (v > 64'sd8388607) return 64'sd8388607;
        if (v < -64'sd8388608) return -64'sd8388608;
        return v;
    endfunction

    // full-cycle sine in q16, quadrant folding of a q30 taylor polynomial
    function automatic longint sine_at(int k);
        logic [63:0] p;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] r;
        logic [63:0] s;
        longint      mag;
        p  = 64'(k) << 22;
        z  = p & 64'h3FFF_FFFF;
        if (p[30]) z = 64'h4000_0000 - z;
        z2 = (z * z) >> 30;
        r  = wt_pkg::SIN_E;
        r  = wt_pkg::SIN_C - ((z2 * r) >> 30);
        r  = wt_pkg::SIN_B - ((z2 * r) >> 30);
        r  = wt_pkg::SIN_A - ((z2 * r) >> 30);
        s  = (z * r) >> 30;
        mag = longint'((s + 64'd8192) >> 14);
        return p[31] ? -mag : mag;
    endfunction

    // appends a command to the tail of the pending queue
    function automatic void add_pending(wave_cmd_t c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    // updates the shadow table and queues the beat the block should return
    task automatic predict_wave(input wave_cmd_t c);
        wave_result_t res;
        longint       peak;
        longint       a;
        longint       n;
        longint       lo;
        longint       hi;
        logic [63:0]  t;
        int           lo_i;
        res = '0;
        case (c.cmd)
            wt_pkg::CMD_CLEAR: begin
                foreach (shadow_table[j]) shadow_table[j] = 0;
            end
            wt_pkg::CMD_WRITE: begin
                shadow_table[c.index] = longint'(c.value);
            end
            wt_pkg::CMD_HARM: begin
                foreach (shadow_table[j]) begin
                    a = (longint'(c.amp) * sine_q16[(c.mult * j) % wt_pkg::TABLE_DEPTH]
                         + 8192) >>> 14;
                    shadow_table[j] = clamp_sample(shadow_table[j] + a);
                end
            end
            wt_pkg::CMD_NORM: begin
                peak = 0;
                foreach (shadow_table[j]) begin
                    a = shadow_table[j] < 0 ? -shadow_table[j] : shadow_table[j];
                    if (a > peak) peak = a;
                end
                if (peak == 0) begin
                    res.silent = 1'b1;
                end else begin
                    foreach (shadow_table[j]) begin
                        a = shadow_table[j] < 0 ? -shadow_table[j] : shadow_table[j];
                        n = ((a << 16) + peak / 2) / peak;
                        shadow_table[j] = clamp_sample(shadow_table[j] < 0 ? -n : n);
                    end
                end
            end
            wt_pkg::CMD_READ: begin
                t    = 64'(c.phase) * wt_pkg::TABLE_DEPTH;
                lo_i = int'(t[41:32]);
                lo   = shadow_table[lo_i];
                hi   = shadow_table[(lo_i + 1) % wt_pkg::TABLE_DEPTH];
                res.sample = 24'(lo + (((hi - lo) * longint'(t[31:16]) + 32768) >>> 16));
            end
            default: ;
        endcase
        expected_results.insert(expected_results.size(), res);
    endtask

    function automatic wave_cmd_t random_cmd(logic [2:0] op);
        wave_cmd_t c;
        c.cmd   = op;
        c.index = 10'($urandom);
        c.value = 24'($urandom);
        c.mult  = 10'($urandom);
        c.amp   = 16'($urandom);
        c.phase = $urandom;
        return c;
    endfunction

    function automatic wave_cmd_t make_cmd(logic [2:0] op, logic [9:0] idx,
                                           logic [23:0] val, logic [9:0] m,
                                           logic [15:0] amp, logic [31:0] ph);
        wave_cmd_t c;
        c = '{phase: ph, amp: amp, mult: m, value: val, index: idx, cmd: op};
        return c;
    endfunction

    // sender: takes the next command from the pending queue, idles now and then
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_wave(offered_cmd);
                beats_in <= beats_in + 1;
            end
            if (!s_tvalid || s_tready) begin
                // quiet stretch in the middle of the random part: no idling at all
                if (pending_cmds.size() > 0 &&
                    ((beats_in > 1000 && beats_in < 1400) || $urandom_range(0, 99) >= 7)) begin
                    offered_cmd = pending_cmds.pop_front();
                    s_tdata  <= {1'b0, offered_cmd};
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off so the block backs up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (!hold_done && beats_out == 600) begin
                hold_done = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= (beats_out > 1000 && beats_out < 1400) ||
                            $urandom_range(0, 99) >= 7;
            end
        end
    end

    // result check against the oldest prediction
    always @(posedge aclk) begin
        wave_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out <= beats_out + 1;
            if (expected_results.size() == 0) begin
                $error("result beat with nothing expected: %h", m_tdata);
                failed = 1;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata[23:0] !== want.sample) begin
                    $error("sample: expected %0d, got %0d",
                           $signed(want.sample), $signed(m_tdata[23:0]));
                    failed = 1;
                end
                if (m_tdata[24] !== want.silent) begin
                    $error("table_silent: expected %0b, got %0b", want.silent, m_tdata[24]);
                    failed = 1;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side; covers normalise and the clear pass
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("wavetable_store_interpolated_read_test: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int pick;
        logic [2:0] op;
        for (int k = 0; k < wt_pkg::TABLE_DEPTH; k++) begin
            sine_q16[k]     = sine_at(k);
            shadow_table[k] = 0;
        end

        // directed: empty table first, then extremes and wrap of the upper index
        add_pending(make_cmd(wt_pkg::CMD_NORM, 0, 0, 0, 0, 0));
        add_pending(make_cmd(wt_pkg::CMD_READ, 0, 0, 0, 0, 32'hFFFF_FFFF));
        add_pending(make_cmd(wt_pkg::CMD_WRITE, 10'd0, 24'h7FFFFF, 0, 0, 0));
        add_pending(make_cmd(wt_pkg::CMD_WRITE, 10'd1023, 24'h800000, 0, 0, 0));
        add_pending(make_cmd(wt_pkg::CMD_WRITE, 10'd1, 24'h000001, 0, 0, 0));
        add_pending(make_cmd(wt_pkg::CMD_READ, 0, 0, 0, 0, 32'h0000_0000));
        add_pending(make_cmd(wt_pkg::CMD_READ, 0, 0, 0, 0, 32'hFFFF_FFFF));
        add_pending(make_cmd(wt_pkg::CMD_READ, 0, 0, 0, 0, 32'hFFC0_8000));
        add_pending(make_cmd(wt_pkg::CMD_READ, 0, 0, 0, 0, 32'h0020_0000));
        // saturating harmonic sums at the lower rail, zero multiplier, wide multiplier
        add_pending(make_cmd(wt_pkg::CMD_HARM, 0, 0, 10'd1, 16'h7FFF, 0));
        add_pending(make_cmd(wt_pkg::CMD_HARM, 0, 0, 10'd1023, 16'h8000, 0));
        add_pending(make_cmd(wt_pkg::CMD_HARM, 0, 0, 10'd0, 16'h7FFF, 0));
        add_pending(make_cmd(wt_pkg::CMD_READ, 0, 0, 0, 0, 32'h4000_0000));
        add_pending(make_cmd(wt_pkg::CMD_NORM, 0, 0, 0, 0, 0));
        add_pending(make_cmd(wt_pkg::CMD_READ, 0, 0, 0, 0, 32'h7FFF_0000));
        add_pending(make_cmd(CMD_SPARE_FIRST, 10'h3FF, 24'hFFFFFF, 10'h3FF,
                             16'hFFFF, 32'hFFFF_FFFF));
        add_pending(make_cmd(CMD_SPARE_MID, 0, 0, 0, 0, 0));
        add_pending(make_cmd(CMD_SPARE_LAST, 0, 0, 0, 0, 0));
        add_pending(make_cmd(wt_pkg::CMD_CLEAR, 0, 0, 0, 0, 0));
        add_pending(make_cmd(wt_pkg::CMD_READ, 0, 0, 0, 0, 32'h1234_5678));
        add_pending(make_cmd(wt_pkg::CMD_NORM, 0, 0, 0, 0, 0));

        // random: mostly writes and reads, the slow table walks kept rare
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            pick = $urandom_range(0, 999);
            if (pick < 20)       op = wt_pkg::CMD_CLEAR;
            else if (pick < 60)  op = wt_pkg::CMD_HARM;
            else if (pick < 66)  op = wt_pkg::CMD_NORM;
            else if (pick < 76)  op = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            else if (pick < 420) op = wt_pkg::CMD_WRITE;
            else                 op = wt_pkg::CMD_READ;
            add_pending(random_cmd(op));
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (!failed) begin
            $display("wavetable_store_interpolated_read_test: clean");
        end else begin
            $display("wavetable_store_interpolated_read_test: errors");
        end
        $finish;
    end

endmodule
